@@ hdl/ssfs_pkg.sv @@
// Shared types and constants for the SCRAM secret field splitter.
package ssfs_pkg;

  localparam int OFF_W   = 10;
  localparam int OFF_NUM = 6;

  // Start offset slots
  localparam logic [2:0] OFF_SALT   = 3'd0;
  localparam logic [2:0] OFF_STORED = 3'd1;
  localparam logic [2:0] OFF_SERVER = 3'd2;
  localparam logic [2:0] OFF_HEX    = 3'd3;
  localparam logic [2:0] OFF_CLEAR  = 3'd4;
  localparam logic [2:0] OFF_SALTED = 3'd5;

  // Mechanism codes
  localparam logic [1:0] MECH_NONE    = 2'd0;
  localparam logic [1:0] MECH_SHA1    = 2'd1;
  localparam logic [1:0] MECH_SHA256  = 2'd2;
  localparam logic [1:0] MECH_SHA512  = 2'd3;

  // Special bytes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Prefix texts, byte 0 first, zero padded to 16 bytes
  typedef logic [0:15][7:0] pfx_text_t;
  localparam pfx_text_t PFX_TEXT [3] = '{
    {"{SCRAM-SHA-1}", 24'h0},
    {"{SCRAM-SHA-256}", 8'h0},
    {"{SCRAM-SHA-512}", 8'h0}
  };
  localparam logic [3:0] PFX_LEN_SHA1 = 4'd13;
  localparam logic [3:0] PFX_LEN_SHA2 = 4'd15;
  localparam logic [3:0] PFX_LEN [3] = '{PFX_LEN_SHA1, PFX_LEN_SHA2, PFX_LEN_SHA2};

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_NOMATCH,
    PH_ITER,
    PH_SALT,
    PH_STORED,
    PH_SERVER,
    PH_AFTER,
    PH_SALTED
  } phase_t;

  // Colon tracking inside the server key
  typedef enum logic [2:0] {
    SUB_NONE,
    SUB_HEX_EMPTY,
    SUB_HEX,
    SUB_CLEAR,
    SUB_MORE
  } sub_t;

  typedef struct packed {
    phase_t                          phase;
    logic [3:0]                      pidx;
    logic [2:0]                      cand;
    logic                            first;
    logic [31:0]                     acc;
    logic                            neg;
    logic                            scan_done;
    logic [OFF_NUM-1:0][OFF_W-1:0]   offs;
    sub_t                            sub;
  } pst_t;

  typedef struct packed {
    logic [3:0]          field_count;
    logic [1:0]          mechanism;
    logic signed [31:0]  iterations;
    logic [OFF_W-1:0]    salt_start;
    logic [OFF_W-1:0]    stored_key_start;
    logic [OFF_W-1:0]    server_key_start;
    logic [OFF_W-1:0]    hex_start;
    logic [OFF_W-1:0]    clear_start;
    logic [OFF_W-1:0]    salted_start;
    logic                too_long;
  } res_t;

endpackage

@@ hdl/ssfs_parser.sv @@
// Byte-wise parser state machine and end-of-string result builder.
module ssfs_parser
  import ssfs_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_acc,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       emit,
  output res_t       res
);

  localparam int POS_W   = $clog2(MAX_LEN + 2);
  localparam int OFF_LIM = (MAX_LEN - 1 > 1023) ? 1023 : MAX_LEN - 1;

  localparam pst_t ST_RESET = '{
    phase:     PH_PREFIX,
    pidx:      4'd0,
    cand:      3'b111,
    first:     1'b0,
    acc:       32'd0,
    neg:       1'b0,
    scan_done: 1'b0,
    offs:      '0,
    sub:       SUB_NONE
  };

  pst_t             st_r, st_nxt, tk, fs;
  logic [POS_W-1:0] pos_r, pos_nxt, tk_pos, fpos;
  logic             term_r, term_nxt;
  logic [2:0]       cand;
  logic [3:0]       idx_n;
  logic [OFF_W-1:0] off, off_next;
  logic             is_digit;
  logic [3:0]       cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_RESET;
      pos_r  <= '0;
      term_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pos_r  <= pos_nxt;
      term_r <= term_nxt;
    end
  end

  // Offsets of the current byte and the one after it, saturated
  assign off      = (pos_r > POS_W'(OFF_LIM)) ? OFF_W'(OFF_LIM) : OFF_W'(pos_r);
  assign off_next = (pos_r >= POS_W'(OFF_LIM)) ? OFF_W'(OFF_LIM)
                                                : OFF_W'(pos_r + POS_W'(1));
  assign is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign tk_pos   = (pos_r <= POS_W'(MAX_LEN)) ? pos_r + POS_W'(1) : pos_r;

  // State after taking one non-zero byte
  always_comb begin
    tk       = st_r;
    tk.first = 1'b0;
    cand     = st_r.cand;
    idx_n    = st_r.pidx + 4'd1;
    case (st_r.phase)
      PH_PREFIX: begin
        for (int k = 0; k < 3; k++) begin
          if (cand[k] && ((st_r.pidx >= PFX_LEN[k]) || (PFX_TEXT[k][st_r.pidx] != in_ch))) begin
            cand[k] = 1'b0;
          end
        end
        tk.pidx = idx_n;
        tk.cand = cand;
        if (cand == 3'b000) begin
          tk.phase = PH_NOMATCH;
        end else if (cand[0] && (idx_n == PFX_LEN_SHA1)) begin
          tk.cand  = 3'b001;
          tk.phase = PH_ITER;
          tk.first = 1'b1;
        end else if ((cand[2:1] != 2'b00) && (idx_n == PFX_LEN_SHA2)) begin
          tk.phase = PH_ITER;
          tk.first = 1'b1;
        end
      end
      PH_ITER: begin
        if (!st_r.first && (in_ch == CH_COMMA)) begin
          tk.phase = PH_SALT;
          tk.first = 1'b1;
        end else if (is_digit && !st_r.scan_done) begin
          tk.acc = {st_r.acc[28:0], 3'b000} + {st_r.acc[30:0], 1'b0} + {28'd0, in_ch[3:0]};
        end else if (st_r.first && (in_ch == CH_MINUS)) begin
          tk.neg = 1'b1;
        end else if (!(st_r.first && (in_ch == CH_PLUS))) begin
          tk.scan_done = 1'b1;
        end
      end
      PH_SALT: begin
        if (st_r.first) tk.offs[OFF_SALT] = off;
        if (!st_r.first && (in_ch == CH_COMMA)) begin
          tk.phase = PH_STORED;
          tk.first = 1'b1;
        end
      end
      PH_STORED: begin
        if (st_r.first) tk.offs[OFF_STORED] = off;
        if (!st_r.first && (in_ch == CH_COMMA)) begin
          tk.phase = PH_SERVER;
          tk.first = 1'b1;
        end
      end
      PH_SERVER: begin
        if (st_r.first) tk.offs[OFF_SERVER] = off;
        if (!st_r.first && (in_ch == CH_COMMA)) begin
          tk.phase = PH_AFTER;
        end else begin
          case (st_r.sub)
            SUB_NONE: begin
              if (in_ch == CH_COLON) begin
                tk.sub           = SUB_HEX_EMPTY;
                tk.offs[OFF_HEX] = off_next;
              end
            end
            SUB_HEX_EMPTY, SUB_HEX: begin
              if (in_ch == CH_COLON) begin
                tk.sub             = SUB_CLEAR;
                tk.offs[OFF_CLEAR] = off_next;
              end else begin
                tk.sub = SUB_HEX;
              end
            end
            default: tk.sub = SUB_MORE;
          endcase
        end
      end
      PH_AFTER: begin
        tk.offs[OFF_SALTED] = off;
        tk.phase            = PH_SALTED;
      end
      default: ;
    endcase
  end

  // Next state: hold after an early zero until the last byte, else advance
  always_comb begin
    emit     = !term_r && ((in_ch == CH_NUL) || in_last);
    st_nxt   = st_r;
    pos_nxt  = pos_r;
    term_nxt = term_r;
    if (in_acc) begin
      if (term_r) begin
        if (in_last) begin
          st_nxt   = ST_RESET;
          pos_nxt  = '0;
          term_nxt = 1'b0;
        end
      end else if (in_ch == CH_NUL) begin
        st_nxt   = ST_RESET;
        pos_nxt  = '0;
        term_nxt = !in_last;
      end else if (in_last) begin
        st_nxt  = ST_RESET;
        pos_nxt = '0;
      end else begin
        st_nxt  = tk;
        pos_nxt = tk_pos;
      end
    end
  end

  // Result from the state the string ends in
  always_comb begin
    fs   = (in_ch == CH_NUL) ? st_r : tk;
    fpos = (in_ch == CH_NUL) ? pos_r : tk_pos;
    case (fs.phase)
      PH_ITER:   cnt = 4'd1;
      PH_SALT:   cnt = 4'd2;
      PH_STORED: cnt = 4'd3;
      PH_SERVER: cnt = 4'd4;
      PH_AFTER:  cnt = 4'd5;
      PH_SALTED: begin
        if (fs.sub == SUB_NONE || fs.sub == SUB_HEX_EMPTY) cnt = 4'd6;
        else if (fs.sub == SUB_HEX || fs.sub == SUB_CLEAR) cnt = 4'd7;
        else                                               cnt = 4'd8;
      end
      default:   cnt = 4'd0;
    endcase
    res.field_count = cnt;
    if (cnt == 4'd0)       res.mechanism = MECH_NONE;
    else if (fs.cand[0])   res.mechanism = MECH_SHA1;
    else if (fs.cand[1])   res.mechanism = MECH_SHA256;
    else                   res.mechanism = MECH_SHA512;
    res.iterations       = (cnt >= 4'd2) ? (fs.neg ? -$signed(fs.acc) : $signed(fs.acc))
                                         : 32'sd0;
    res.salt_start       = (cnt >= 4'd3) ? fs.offs[OFF_SALT]   : '0;
    res.stored_key_start = (cnt >= 4'd4) ? fs.offs[OFF_STORED] : '0;
    res.server_key_start = (cnt >= 4'd5) ? fs.offs[OFF_SERVER] : '0;
    res.hex_start        = (cnt >= 4'd7) ? fs.offs[OFF_HEX]    : '0;
    res.clear_start      = (cnt >= 4'd8) ? fs.offs[OFF_CLEAR]  : '0;
    res.salted_start     = (cnt >= 4'd6) ? fs.offs[OFF_SALTED] : '0;
    res.too_long         = fpos > POS_W'(MAX_LEN);
  end

endmodule

@@ hdl/scram_secret_field_splitter_unit.sv @@
// Top level of the SCRAM secret field splitter: handshake and result register.
// Output: the result of a string appears on out_valid in the cycle after its
//   ending byte request (zero byte or byte with last set) is accepted.
// One byte request per cycle unless stalled; parser state update is the only loop.
// Reset: synchronous, active low; clears the parser to prefix matching and
//   empties the result register.
module scram_secret_field_splitter_unit
  import ssfs_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // byte requests
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_ch,
  input  logic                    in_last,
  // result requests
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              out_field_count,
  output logic [1:0]              out_mechanism,
  output logic signed [31:0]      out_iterations,
  output logic [OFF_W-1:0]        out_salt_start,
  output logic [OFF_W-1:0]        out_stored_key_start,
  output logic [OFF_W-1:0]        out_server_key_start,
  output logic [OFF_W-1:0]        out_hex_start,
  output logic [OFF_W-1:0]        out_clear_start,
  output logic [OFF_W-1:0]        out_salted_start,
  output logic                    out_too_long
);

  logic in_acc;
  logic emit;
  res_t res;
  res_t out_res_r;
  logic out_valid_r, out_valid_nxt;

  // Parser: holds all per-string state and builds the result in the
  // same cycle as the ending byte.
  ssfs_parser #(
    .MAX_LEN (MAX_LEN)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_ch   (in_ch),
    .in_last (in_last),
    .emit    (emit),
    .res     (res)
  );

  // Stall only a request that ends a string while the result register
  // still holds an untaken result; bytes inside a string keep flowing.
  assign in_stall = out_valid_r && out_stall && emit;
  assign in_acc   = in_valid && !in_stall;

  // Load on an ending byte, drop once taken, otherwise hold.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_field_count      = out_res_r.field_count;
  assign out_mechanism        = out_res_r.mechanism;
  assign out_iterations       = out_res_r.iterations;
  assign out_salt_start       = out_res_r.salt_start;
  assign out_stored_key_start = out_res_r.stored_key_start;
  assign out_server_key_start = out_res_r.server_key_start;
  assign out_hex_start        = out_res_r.hex_start;
  assign out_clear_start      = out_res_r.clear_start;
  assign out_salted_start     = out_res_r.salted_start;
  assign out_too_long         = out_res_r.too_long;

  // An ending byte that is accepted always shows a result next cycle.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit |=> out_valid)
    else $error("accepted ending byte produced no result");

  // No mechanism exactly when no field was found.
  a_mech_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_mechanism == MECH_NONE) == (out_field_count == 4'd0)))
    else $error("mechanism and field count disagree");

  // Field count stays in range and unset iterations, salt and clear fields read as zero.
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_field_count <= 4'd8)
                  && (out_field_count >= 4'd2 || out_iterations == 32'sd0)
                  && (out_field_count >= 4'd3 || out_salt_start == '0)
                  && (out_field_count >= 4'd8 || out_clear_start == '0))
    else $error("field count out of range or stale field offset");

endmodule
